FILE: rtl/baro_pressure_compensation_defines.svh
// Assertion macros used by the verification checker of the pressure compensation block.
// Depends on nothing; included by the checker file.
`ifndef BARO_PRESSURE_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_COMPENSATION_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define BPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define BPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after the antecedent, reset included.
`define BPC_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bpc_pkg.sv
// Package of the pressure compensation block: fixed-point helpers and the divider tag type.
// Depends on nothing; used by the top level and the divider of the block.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    localparam int unsigned DivSteps = 32;

    typedef struct packed {
        logic [20:0] fine;
        logic        err;
        logic        dbl;
    } bpc_tag_t;

    function automatic logic [31:0] sra(input logic [31:0] x, input int unsigned n);
        logic signed [31:0] s;
        s = $signed(x);
        return 32'(s >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = a * b;
        return prod[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/baro_pressure_compensation.sv
// Top level of the barometric pressure compensation block: a fully pipelined integer datapath.
// Depends on bpc_pkg and bpc_divider.
`timescale 1ns / 1ps
`default_nettype none

// The block accepts one raw reading in every clock cycle, since busy stays low, and delivers
// the result with done high for one cycle; the receiver cannot stall. The result passes
// through eight arithmetic stages ahead of the divider, the 33 stages of the
// bit-per-stage divider and three stages of final correction. Coefficients must be written
// only while no reading is in flight.
module baro_pressure_compensation (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [7:0]         pressure_msb,
    input  wire logic [7:0]         pressure_lsb,
    input  wire logic [7:0]         pressure_xlsb,
    input  wire logic [7:0]         temperature_msb,
    input  wire logic [7:0]         temperature_lsb,
    input  wire logic [7:0]         temperature_xlsb,
    output logic                    done,
    output logic signed [20:0]      fine_temperature,
    output logic [19:0]             pressure_pa,
    output logic                    divide_error
);

    localparam logic [1:0] RegTemp  = 2'd0;
    localparam logic [1:0] RegPLow  = 2'd1;
    localparam logic [1:0] RegPHigh = 2'd2;
    localparam logic [1:0] RegPNine = 2'd3;

    logic [47:0] temp_reg;
    logic [63:0] plow_reg;
    logic [63:0] phigh_reg;
    logic [15:0] p9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg  <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            p9_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegTemp:  temp_reg  <= cfg_data[47:0];
                RegPLow:  plow_reg  <= cfg_data;
                RegPHigh: phigh_reg <= cfg_data;
                RegPNine: p9_reg    <= cfg_data[15:0];
                default:  temp_reg  <= temp_reg;
            endcase
        end
    end

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, temp_reg[15:0]};
    assign t2 = bpc_pkg::sx16(temp_reg[31:16]);
    assign t3 = bpc_pkg::sx16(temp_reg[47:32]);
    assign p1 = {16'd0, plow_reg[15:0]};
    assign p2 = bpc_pkg::sx16(plow_reg[31:16]);
    assign p3 = bpc_pkg::sx16(plow_reg[47:32]);
    assign p4 = bpc_pkg::sx16(plow_reg[63:48]);
    assign p5 = bpc_pkg::sx16(phigh_reg[15:0]);
    assign p6 = bpc_pkg::sx16(phigh_reg[31:16]);
    assign p7 = bpc_pkg::sx16(phigh_reg[47:32]);
    assign p8 = bpc_pkg::sx16(phigh_reg[63:48]);
    assign p9 = bpc_pkg::sx16(p9_reg);

    assign busy = 1'b0;

    logic [10:0] v_reg;
    logic        div_out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg[7:0]  <= {v_reg[6:0], start};
            v_reg[8]    <= div_out_valid;
            v_reg[10:9] <= {v_reg[9], v_reg[8]};
        end
    end

    logic [31:0] adc_p, adc_t, d_t;
    assign adc_p = {12'd0, pressure_msb, pressure_lsb, pressure_xlsb[7:4]};
    assign adc_t = {12'd0, temperature_msb, temperature_lsb, temperature_xlsb[7:4]};
    assign d_t   = (adc_t >> 4) - t1;

    logic [31:0] s1_m1_reg, s1_dd_reg, s1_adcp_reg;
    logic [31:0] s2_a_reg, s2_m2_reg, s2_adcp_reg;
    logic [31:0] s3_fine_reg, s3_pa_reg, s3_adcp_reg;
    logic [31:0] s4_sq_reg, s4_m5_reg, s4_m2_reg, s4_adcp_reg;
    logic [20:0] s4_fsat_reg;
    logic [31:0] s5_b1_reg, s5_m3_reg, s5_m5_reg, s5_m2_reg, s5_adcp_reg;
    logic [20:0] s5_fsat_reg;
    logic [31:0] s6_b_reg, s6_a_reg, s6_adcp_reg;
    logic [20:0] s6_fsat_reg;
    logic [31:0] s7_m_reg, s7_x_reg;
    logic [20:0] s7_fsat_reg;
    logic [31:0] s8_den_reg, s8_pm_reg;
    logic [20:0] s8_fsat_reg;

    logic [31:0] s3_fine_next, s6_b_next, s6_a_next;
    logic [20:0] fsat_next;

    assign s3_fine_next = s2_a_reg + bpc_pkg::sra(s2_m2_reg, 14);
    assign s6_b_next = bpc_pkg::sra(s5_b1_reg + (s5_m5_reg << 1), 2) + (p4 << 16);
    assign s6_a_next = bpc_pkg::sra(bpc_pkg::sra(s5_m3_reg, 3) + bpc_pkg::sra(s5_m2_reg, 1), 18);

    always_comb
    begin
        if (s3_fine_reg[31:20] == {12{s3_fine_reg[31]}})
        begin
            fsat_next = s3_fine_reg[20:0];
        end
        else if (s3_fine_reg[31])
        begin
            fsat_next = {1'b1, 20'd0};
        end
        else
        begin
            fsat_next = {1'b0, {20{1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_m1_reg   <= bpc_pkg::mul32((adc_t >> 3) - (t1 << 1), t2);
        s1_dd_reg   <= bpc_pkg::mul32(d_t, d_t);
        s1_adcp_reg <= adc_p;

        s2_a_reg    <= bpc_pkg::sra(s1_m1_reg, 11);
        s2_m2_reg   <= bpc_pkg::mul32(bpc_pkg::sra(s1_dd_reg, 12), t3);
        s2_adcp_reg <= s1_adcp_reg;

        s3_fine_reg <= s3_fine_next;
        s3_pa_reg   <= bpc_pkg::sra(s3_fine_next, 1) - 32'd64000;
        s3_adcp_reg <= s2_adcp_reg;

        s4_sq_reg   <= bpc_pkg::mul32(bpc_pkg::sra(s3_pa_reg, 2), bpc_pkg::sra(s3_pa_reg, 2));
        s4_m5_reg   <= bpc_pkg::mul32(s3_pa_reg, p5);
        s4_m2_reg   <= bpc_pkg::mul32(p2, s3_pa_reg);
        s4_adcp_reg <= s3_adcp_reg;
        s4_fsat_reg <= fsat_next;

        s5_b1_reg   <= bpc_pkg::mul32(bpc_pkg::sra(s4_sq_reg, 11), p6);
        s5_m3_reg   <= bpc_pkg::mul32(p3, bpc_pkg::sra(s4_sq_reg, 13));
        s5_m5_reg   <= s4_m5_reg;
        s5_m2_reg   <= s4_m2_reg;
        s5_adcp_reg <= s4_adcp_reg;
        s5_fsat_reg <= s4_fsat_reg;

        s6_b_reg    <= s6_b_next;
        s6_a_reg    <= s6_a_next;
        s6_adcp_reg <= s5_adcp_reg;
        s6_fsat_reg <= s5_fsat_reg;

        s7_m_reg    <= bpc_pkg::mul32(32'd32768 + s6_a_reg, p1);
        s7_x_reg    <= (32'd1048576 - s6_adcp_reg) - bpc_pkg::sra(s6_b_reg, 12);
        s7_fsat_reg <= s6_fsat_reg;

        s8_den_reg  <= bpc_pkg::sra(s7_m_reg, 15);
        s8_pm_reg   <= bpc_pkg::mul32(s7_x_reg, 32'd3125);
        s8_fsat_reg <= s7_fsat_reg;
    end

    bpc_pkg::bpc_tag_t div_in_tag;
    bpc_pkg::bpc_tag_t div_out_tag;
    logic [31:0]       div_num;
    logic [31:0]       div_quot;

    always_comb
    begin
        div_in_tag.fine = s8_fsat_reg;
        div_in_tag.err  = (s8_den_reg == 32'd0);
        div_in_tag.dbl  = s8_pm_reg[31];
        div_num         = s8_pm_reg[31] ? s8_pm_reg : (s8_pm_reg << 1);
    end

    bpc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[7]),
        .num       (div_num),
        .den       (s8_den_reg),
        .in_tag    (div_in_tag),
        .out_valid (div_out_valid),
        .quot      (div_quot),
        .out_tag   (div_out_tag)
    );

    logic [31:0] p_q;
    assign p_q = div_out_tag.dbl ? (div_quot << 1) : div_quot;

    logic [31:0]       sa_sq_reg, sa_c2_reg, sa_p_reg;
    bpc_pkg::bpc_tag_t sa_tag_reg;
    logic [31:0]       sb_c1_reg, sb_c2_reg, sb_p_reg;
    bpc_pkg::bpc_tag_t sb_tag_reg;
    logic [19:0]       sc_pres_reg;
    bpc_pkg::bpc_tag_t sc_tag_reg;

    logic [31:0] corr;
    logic [33:0] res;
    logic [19:0] pres_next;

    always_comb
    begin
        corr = bpc_pkg::sra(bpc_pkg::sra(sb_c1_reg, 12) + bpc_pkg::sra(sb_c2_reg, 13) + p7, 4);
        res  = {2'b00, sb_p_reg} + {{2{corr[31]}}, corr};
        if (sb_tag_reg.err)
        begin
            pres_next = '0;
        end
        else if (res[33])
        begin
            pres_next = '0;
        end
        else if (res[32:20] != 13'd0)
        begin
            pres_next = {20{1'b1}};
        end
        else
        begin
            pres_next = res[19:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sa_sq_reg   <= bpc_pkg::mul32(p_q >> 3, p_q >> 3);
        sa_c2_reg   <= bpc_pkg::mul32(p_q >> 2, p8);
        sa_p_reg    <= p_q;
        sa_tag_reg  <= div_out_tag;

        sb_c1_reg   <= bpc_pkg::mul32(p9, sa_sq_reg >> 13);
        sb_c2_reg   <= sa_c2_reg;
        sb_p_reg    <= sa_p_reg;
        sb_tag_reg  <= sa_tag_reg;

        sc_pres_reg <= pres_next;
        sc_tag_reg  <= sb_tag_reg;
    end

    assign done             = v_reg[10];
    assign fine_temperature = $signed(sc_tag_reg.fine);
    assign pressure_pa      = sc_pres_reg;
    assign divide_error     = sc_tag_reg.err;

endmodule

`default_nettype wire

FILE: rtl/bpc_divider.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, with a tag beside the data.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpc_divider (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [31:0]      num,
    input  wire logic [31:0]      den,
    input  bpc_pkg::bpc_tag_t     in_tag,
    output logic                  out_valid,
    output logic [31:0]           quot,
    output bpc_pkg::bpc_tag_t     out_tag
);

    localparam int unsigned N = bpc_pkg::DivSteps;

    logic [N:0]        valid_reg;
    logic [31:0]       rem_reg  [N+1];
    logic [31:0]       numq_reg [N+1];
    logic [31:0]       den_reg  [N+1];
    bpc_pkg::bpc_tag_t tag_reg  [N+1];

    logic [31:0] rem_next  [N];
    logic [31:0] numq_next [N];

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            logic [32:0] trial;
            logic [32:0] diff;
            trial = {rem_reg[k], numq_reg[k][31]};
            diff  = trial - {1'b0, den_reg[k]};
            if (!diff[32])
            begin
                rem_next[k]  = diff[31:0];
                numq_next[k] = {numq_reg[k][30:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = trial[31:0];
                numq_next[k] = {numq_reg[k][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        numq_reg[0] <= num;
        den_reg[0]  <= den;
        tag_reg[0]  <= in_tag;
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k+1]  <= rem_next[k];
            numq_reg[k+1] <= numq_next[k];
            den_reg[k+1]  <= den_reg[k];
            tag_reg[k+1]  <= tag_reg[k];
        end
    end

    assign out_valid = valid_reg[N];
    assign quot      = numq_reg[N];
    assign out_tag   = tag_reg[N];

endmodule

`default_nettype wire

FILE: rtl/bpc_checker.sv
// Port-level checker for the pressure compensation block, with its bind to the top level.
// Depends on baro_pressure_compensation_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "baro_pressure_compensation_defines.svh"

module bpc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [19:0] pressure_pa,
    input wire logic        divide_error
);

    `BPC_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "block refused a transfer")
    `BPC_ASSERT_IMPLY(a_err_zero, clk, rst_n, done && divide_error, pressure_pa == 20'd0, "pressure not zero on divide error")
    `BPC_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !done, "result strobe right after reset")

endmodule

bind baro_pressure_compensation bpc_checker u_bpc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .done         (done),
    .pressure_pa  (pressure_pa),
    .divide_error (divide_error)
);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench of the barometric pressure compensation block.
// Drives raw readings and calibration writes, and checks every result against a local predictor.
// Depends on baro_pressure_compensation and its RTL files.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] REG_TEMP = 2'd0;
    localparam logic [1:0] REG_PLOW = 2'd1;
    localparam logic [1:0] REG_PHIGH = 2'd2;
    localparam logic [1:0] REG_P9 = 2'd3;
    localparam int LATENCY = 44;

    typedef struct packed {
        logic [7:0] pm, pl, px, tm, tl, tx;
    } reading_t;

    typedef struct packed {
        logic [20:0] fine;
        logic [19:0] pa;
        logic        err;
    } comp_t;

    typedef struct {
        reading_t   rd;
        logic       has_exp;
        comp_t      exp;
    } row_t;

    logic clk, rst_n, cfg_we, start, busy, done, divide_error;
    logic [1:0] cfg_index;
    logic [63:0] cfg_data;
    logic [7:0] pressure_msb, pressure_lsb, pressure_xlsb;
    logic [7:0] temperature_msb, temperature_lsb, temperature_xlsb;
    logic signed [20:0] fine_temperature;
    logic [19:0] pressure_pa;

    logic [47:0] cal_temp;
    logic [63:0] cal_plow, cal_phigh;
    logic [15:0] cal_p9;
    comp_t pending_results[$];
    int failures;

    baro_pressure_compensation DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy),
        .pressure_msb(pressure_msb), .pressure_lsb(pressure_lsb),
        .pressure_xlsb(pressure_xlsb), .temperature_msb(temperature_msb),
        .temperature_lsb(temperature_lsb), .temperature_xlsb(temperature_xlsb),
        .done(done), .fine_temperature(fine_temperature), .pressure_pa(pressure_pa),
        .divide_error(divide_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [31:0] asr(input logic [31:0] x, input int n);
        logic signed [31:0] s;
        s = x;
        return s >>> n;
    endfunction

    function automatic logic [31:0] wmul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] pr;
        pr = {32'd0, a} * {32'd0, b};
        return pr[31:0];
    endfunction

    function automatic logic [31:0] cext(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic comp_t compensate(input reading_t rd);
        logic [31:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, sq, fine, p, c1, c2, corr;
        longint res, fs;
        comp_t r;
        adc_p = {12'd0, rd.pm, rd.pl, rd.px[7:4]};
        adc_t = {12'd0, rd.tm, rd.tl, rd.tx[7:4]};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = cext(cal_temp[31:16]);
        t3 = cext(cal_temp[47:32]);
        p1 = {16'd0, cal_plow[15:0]};
        p2 = cext(cal_plow[31:16]);
        p3 = cext(cal_plow[47:32]);
        p4 = cext(cal_plow[63:48]);
        p5 = cext(cal_phigh[15:0]);
        p6 = cext(cal_phigh[31:16]);
        p7 = cext(cal_phigh[47:32]);
        p8 = cext(cal_phigh[63:48]);
        p9 = cext(cal_p9);
        a = asr(wmul((adc_t >> 3) - (t1 << 1), t2), 11);
        d = (adc_t >> 4) - t1;
        b = asr(wmul(asr(wmul(d, d), 12), t3), 14);
        fine = a + b;
        a = asr(fine, 1) - 32'd64000;
        d = asr(a, 2);
        sq = wmul(d, d);
        b = wmul(asr(sq, 11), p6);
        b = b + (wmul(a, p5) << 1);
        b = asr(b, 2) + (p4 << 16);
        a = asr(asr(wmul(p3, asr(sq, 13)), 3) + asr(wmul(p2, a), 1), 18);
        a = asr(wmul(32'd32768 + a, p1), 15);
        if (a == 0)
        begin
            r.err = 1'b1;
            r.pa = '0;
        end
        else
        begin
            r.err = 1'b0;
            p = wmul((32'd1048576 - adc_p) - asr(b, 12), 32'd3125);
            if (p < 32'h8000_0000)
                p = (p << 1) / a;
            else
                p = (p / a) << 1;
            c1 = asr(wmul(p9, wmul(p >> 3, p >> 3) >> 13), 12);
            c2 = asr(wmul(p >> 2, p8), 13);
            corr = asr(c1 + c2 + p7, 4);
            res = longint'({32'd0, p}) + longint'($signed(corr));
            if (res < 0)
                res = 0;
            if (res > 1048575)
                res = 1048575;
            r.pa = res[19:0];
        end
        fs = longint'($signed(fine));
        if (fs > 1048575)
            fs = 1048575;
        if (fs < -1048576)
            fs = -1048576;
        r.fine = fs[20:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        comp_t e;
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expectation waiting");
                failures++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (fine_temperature !== e.fine)
                begin
                    $error("fine_temperature expected %0d actual %0d",
                           $signed(e.fine), fine_temperature);
                    failures++;
                end
                if (pressure_pa !== e.pa)
                begin
                    $error("pressure_pa expected %0d actual %0d", e.pa, pressure_pa);
                    failures++;
                end
                if (divide_error !== e.err)
                begin
                    $error("divide_error expected %0d actual %0d", e.err, divide_error);
                    failures++;
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_TEMP: cal_temp = val[47:0];
            REG_PLOW: cal_plow = val;
            REG_PHIGH: cal_phigh = val;
            default: cal_p9 = val[15:0];
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send(input reading_t rd, input logic has_exp, input comp_t ex,
                        input int gap);
        comp_t pr;
        cfg_we <= 1'b0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pressure_msb <= rd.pm;
        pressure_lsb <= rd.pl;
        pressure_xlsb <= rd.px;
        temperature_msb <= rd.tm;
        temperature_lsb <= rd.tl;
        temperature_xlsb <= rd.tx;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pr = compensate(rd);
        if (has_exp && pr !== ex)
        begin
            $error("directed row disagrees with predictor");
            failures++;
        end
        pending_results.push_back(pr);
    endtask

    task automatic random_calibration();
        // Typical factory words: T1 from 26000 to 29000, P1 from 30000 to 40000, keep the divisor well away from zero.
        write_reg(REG_TEMP, {16'($urandom_range(0, 65535)), 16'($urandom_range(26000, 27500)),
                             16'($urandom_range(26000, 29000))});
        write_reg(REG_PLOW, {16'($urandom_range(0, 65535) | 16'h0), 16'($urandom),
                             16'($urandom), 16'($urandom_range(30000, 40000))});
        write_reg(REG_PHIGH, {$urandom, $urandom});
        write_reg(REG_P9, 64'($urandom));
    endtask

    function automatic reading_t random_reading();
        return {$urandom, 16'($urandom)};
    endfunction

    row_t directed[$];

    initial
    begin
        row_t rw;
        int gap;
        comp_t zero_err;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TEMP;
        cfg_data = '0;
        start = 1'b0;
        {pressure_msb, pressure_lsb, pressure_xlsb} = '0;
        {temperature_msb, temperature_lsb, temperature_xlsb} = '0;
        cal_temp = '0;
        cal_plow = '0;
        cal_phigh = '0;
        cal_p9 = '0;
        failures = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all coefficients zero the divisor is zero and the fine temperature is zero.
        zero_err = '{fine: '0, pa: '0, err: 1'b1};
        rw.has_exp = 1'b1;
        rw.exp = zero_err;
        rw.rd = '0;
        directed.push_back(rw);
        rw.rd = '1;
        directed.push_back(rw);
        rw.rd = {8'h80, 8'h00, 8'h0F, 8'h80, 8'h00, 8'h0F};
        directed.push_back(rw);
        foreach (directed[i])
            send(directed[i].rd, directed[i].has_exp, directed[i].exp, 0);
        drain();

        // Typical calibration set; extreme readings checked against the predictor.
        write_reg(REG_TEMP, {16'sd50, 16'sd26435, 16'd27504});
        write_reg(REG_PLOW, {16'sd2855, 16'sd24, -16'sd10685, 16'd36477});
        write_reg(REG_PHIGH, {-16'sd12000, 16'sd15500, -16'sd7, 16'sd140});
        write_reg(REG_P9, 64'd6000);
        directed.delete();
        rw.has_exp = 1'b0;
        rw.rd = '0;
        directed.push_back(rw);
        rw.rd = '1;
        directed.push_back(rw);
        rw.rd = {8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00};
        directed.push_back(rw);
        rw.rd = {8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h00};
        directed.push_back(rw);
        rw.rd = {8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0};
        directed.push_back(rw);
        rw.rd = {8'h55, 8'hAA, 8'h5A, 8'hAA, 8'h55, 8'hA5};
        directed.push_back(rw);
        foreach (directed[i])
            send(directed[i].rd, 1'b0, zero_err, $urandom_range(0, 2));
        drain();

        // Extreme coefficient words drive saturation of both outputs.
        write_reg(REG_TEMP, 64'hFFFF_8000_7FFF_0000);
        write_reg(REG_PLOW, 64'h7FFF_8000_7FFF_FFFF);
        write_reg(REG_PHIGH, 64'h8000_7FFF_8000_7FFF);
        write_reg(REG_P9, 64'hFFFF_FFFF_FFFF_8000);
        for (int i = 0; i < 8; i++)
            send(random_reading(), 1'b0, zero_err, $urandom_range(0, 1));
        drain();
        write_reg(REG_P9, 64'h7FFF);
        write_reg(REG_PHIGH, '1);
        for (int i = 0; i < 6; i++)
            send(random_reading(), 1'b0, zero_err, 0);
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase % 4 == 3)
            begin
                write_reg(REG_TEMP, {$urandom, $urandom});
                write_reg(REG_PLOW, {$urandom, $urandom});
                write_reg(REG_PHIGH, {$urandom, $urandom});
                write_reg(REG_P9, {$urandom, $urandom});
            end
            else
                random_calibration();
            for (int i = 0; i < 100; i++)
            begin
                if (phase % 3 == 1)
                    gap = 0;
                else
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                send(random_reading(), 1'b0, zero_err, gap);
            end
            drain();
        end

        if (failures == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_divider.sv
rtl/baro_pressure_compensation.sv
rtl/bpc_checker.sv
dv/testbench.sv
